// ===== sv/dcis_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dcis_pkg
// Shared types and constants of the daisy-chain input slave: symbol codes,
// field widths and the response handed from the phase control to the emitter.
// ----------------------------------------------------------------------------
package dcis_pkg;

	localparam int SYM_W          = 3;
	localparam int LOCAL_W        = 8;
	localparam int IN_TDATA_W     = 16;  // symbol + local_bits, padded to bytes
	localparam int OUT_TDATA_W    = 8;   // out_symbol, padded to a byte
	localparam int NUM_INPUTS_DEF = 8;

	localparam logic [SYM_W-1:0] SYM_GROWL = 3'd2;
	localparam logic [SYM_W-1:0] SYM_BARK  = 3'd3;
	localparam logic [SYM_W-1:0] SYM_HOWL  = 3'd4;

	typedef enum logic [1:0] {
		RESP_NONE,
		RESP_SINGLE,
		RESP_BURST
	} resp_kind_t;

	typedef struct packed {
		resp_kind_t       kind;
		logic [SYM_W-1:0] sym;
	} resp_t;

endpackage

`default_nettype wire

// ===== sv/dcis_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dcis_ctrl
// Phase and copy counter of the slave. Decides, for the symbol on the input,
// whether nothing, one symbol or a full local frame goes downstream, and
// updates the phase on each accepted transaction.
// ----------------------------------------------------------------------------
module dcis_ctrl
	import dcis_pkg::*;
#(
	parameter int NUM_INPUTS = NUM_INPUTS_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              accept,
	input  wire              mode,
	input  wire [SYM_W-1:0]  symbol,
	output resp_t            resp
);

	localparam int CLW = $clog2(NUM_INPUTS + 1);
	localparam logic [CLW-1:0] CL_INIT = CLW'(NUM_INPUTS);
	localparam logic [CLW-1:0] CL_ONE  = CLW'(1);

	localparam logic [1:0] PH_REST  = 2'd0;
	localparam logic [1:0] PH_ALERT = 2'd1;
	localparam logic [1:0] PH_COPY  = 2'd2;

	logic [1:0]     phase_q;
	logic [1:0]     phase_eff;
	logic [1:0]     phase_nxt;
	logic [CLW-1:0] copy_left_q;
	logic [CLW-1:0] copy_left_eff;
	logic [CLW-1:0] copy_left_nxt;

	always_comb begin
		// a reset command forces rest before the symbol is handled
		phase_eff     = mode ? PH_REST : phase_q;
		copy_left_eff = mode ? CL_INIT : copy_left_q;
		phase_nxt     = phase_eff;
		copy_left_nxt = copy_left_eff;
		resp.kind     = RESP_NONE;
		resp.sym      = symbol;
		case (phase_eff)
			PH_ALERT: begin
				if (symbol != SYM_HOWL) begin
					resp.kind = RESP_SINGLE;
					resp.sym  = SYM_BARK;
					phase_nxt = PH_COPY;
				end else begin
					resp.kind = RESP_BURST;
					resp.sym  = SYM_BARK;
					phase_nxt = PH_REST;
				end
			end
			PH_COPY: begin
				resp.kind = RESP_SINGLE;
				if (copy_left_eff <= CL_ONE) begin
					phase_nxt     = PH_ALERT;
					copy_left_nxt = CL_INIT;
				end else begin
					copy_left_nxt = copy_left_eff - CL_ONE;
				end
			end
			default: begin
				// rest, and the unused code acting as rest
				phase_nxt = PH_REST;
				if (symbol == SYM_GROWL) begin
					resp.kind = RESP_SINGLE;
					phase_nxt = PH_ALERT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_REST;
			copy_left_q <= CL_INIT;
		end else if (accept) begin
			phase_q     <= phase_nxt;
			copy_left_q <= copy_left_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== sv/dcis_emit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dcis_emit
// Output register and frame serializer. A single response goes straight to
// the output register; a local frame sends bark, then the local bits one per
// transaction out of a shift register, then growl and howl.
// ----------------------------------------------------------------------------
module dcis_emit
	import dcis_pkg::*;
#(
	parameter int NUM_INPUTS = NUM_INPUTS_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                load,
	input  resp_t              resp,
	input  wire  [LOCAL_W-1:0] local_bits,
	input  wire                out_ready,
	output logic               out_valid,
	output logic [SYM_W-1:0]   out_symbol,
	output logic               out_last,
	output logic               busy
);

	localparam int CW = $clog2(NUM_INPUTS + 1);
	localparam logic [CW-1:0] CNT_INIT = CW'(NUM_INPUTS);
	localparam logic [CW-1:0] CNT_ONE  = CW'(1);

	localparam logic [1:0] E_IDLE  = 2'd0;
	localparam logic [1:0] E_BITS  = 2'd1;
	localparam logic [1:0] E_GROWL = 2'd2;
	localparam logic [1:0] E_HOWL  = 2'd3;

	logic [1:0]         state_q;
	logic [1:0]         state_nxt;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      cnt_nxt;
	logic [LOCAL_W-1:0] shift_q;
	logic [LOCAL_W-1:0] shift_nxt;
	logic               ovalid_q;
	logic [SYM_W-1:0]   osym_q;
	logic               olast_q;
	logic               adv;
	logic               emit;
	logic [SYM_W-1:0]   emit_sym;
	logic               emit_last;

	assign adv        = !ovalid_q || out_ready;
	assign busy       = (state_q != E_IDLE);
	assign out_valid  = ovalid_q;
	assign out_symbol = osym_q;
	assign out_last   = olast_q;

	always_comb begin
		state_nxt = state_q;
		cnt_nxt   = cnt_q;
		shift_nxt = shift_q;
		emit      = 1'b0;
		emit_sym  = resp.sym;
		emit_last = 1'b0;
		case (state_q)
			E_IDLE: begin
				if (load) begin
					case (resp.kind)
						RESP_SINGLE: begin
							emit      = 1'b1;
							emit_last = 1'b1;
						end
						RESP_BURST: begin
							emit      = 1'b1;
							emit_sym  = SYM_BARK;
							state_nxt = E_BITS;
							cnt_nxt   = CNT_INIT;
							shift_nxt = local_bits;
						end
						default: begin
							emit = 1'b0;
						end
					endcase
				end
			end
			E_BITS: begin
				if (adv) begin
					// send bit 0, shift zeros in behind the field
					emit      = 1'b1;
					emit_sym  = {{(SYM_W-1){1'b0}}, shift_q[0]};
					shift_nxt = shift_q >> 1;
					cnt_nxt   = cnt_q - CNT_ONE;
					if (cnt_q == CNT_ONE) begin
						state_nxt = E_GROWL;
					end
				end
			end
			E_GROWL: begin
				if (adv) begin
					emit      = 1'b1;
					emit_sym  = SYM_GROWL;
					state_nxt = E_HOWL;
				end
			end
			E_HOWL: begin
				if (adv) begin
					emit      = 1'b1;
					emit_sym  = SYM_HOWL;
					emit_last = 1'b1;
					state_nxt = E_IDLE;
				end
			end
			default: begin
				state_nxt = E_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= E_IDLE;
			cnt_q    <= CNT_INIT;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			cnt_q   <= cnt_nxt;
			if (adv) begin
				ovalid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		shift_q <= shift_nxt;
		if (adv && emit) begin
			osym_q  <= emit_sym;
			olast_q <= emit_last;
		end
	end

endmodule

`default_nettype wire

// ===== sv/daisy_chain_input_slave.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// daisy_chain_input_slave
// One slave of a daisy-chained polling line: forwards, absorbs or copies line
// symbols and answers the end symbol with a frame of its own local bits.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                          | tuser | tlast
//  s_*     | in        | symbol[2:0], local_bits[10:3]  | mode  | -
//  m_*     | out       | out_symbol[2:0]                | -     | last
//
//  An input transaction yields zero or one output transaction, except a howl
//  while alert, which yields NUM_INPUTS + 3 output transactions at one per cycle
//  while m_tready is high, serialized through the local bit shift register; no
//  input is taken until the final howl of that frame is loaded.
//  Reset puts the slave in rest with the copy counter at NUM_INPUTS.
//  A single output register holds a stalled result; s_tready also needs !busy.
// ----------------------------------------------------------------------------
module daisy_chain_input_slave
	import dcis_pkg::*;
#(
	parameter int NUM_INPUTS = NUM_INPUTS_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   s_tvalid,
	output logic                  s_tready,
	input  wire  [IN_TDATA_W-1:0] s_tdata,   // symbol[2:0], local_bits[10:3], zero pad
	input  wire                   s_tuser,   // mode
	output logic                  m_tvalid,
	input  wire                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // out_symbol[2:0], zero pad
	output logic                  m_tlast
);

	logic               s_acc;
	logic               busy;
	logic [SYM_W-1:0]   in_symbol;
	logic [LOCAL_W-1:0] in_local_bits;
	logic [SYM_W-1:0]   out_symbol;
	resp_t              resp;

	assign in_symbol     = s_tdata[SYM_W-1:0];
	assign in_local_bits = s_tdata[SYM_W+LOCAL_W-1:SYM_W];
	assign s_tready      = !busy && (!m_tvalid || m_tready);
	assign s_acc         = s_tvalid && s_tready;
	assign m_tdata       = {{(OUT_TDATA_W-SYM_W){1'b0}}, out_symbol};

	dcis_ctrl #(
		.NUM_INPUTS(NUM_INPUTS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (s_acc),
		.mode   (s_tuser),
		.symbol (in_symbol),
		.resp   (resp)
	);

	dcis_emit #(
		.NUM_INPUTS(NUM_INPUTS)
	) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (s_acc),
		.resp       (resp),
		.local_bits (in_local_bits),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_symbol (out_symbol),
		.out_last   (m_tlast),
		.busy       (busy)
	);

	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_tready)
		else $error("input taken while a frame is being sent");

	a_frame_starts_with_bark: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && (resp.kind == RESP_BURST)
		|=> m_tvalid && (m_tdata[SYM_W-1:0] == SYM_BARK) && !m_tlast && busy)
		else $error("local frame did not open with bark");

	a_single_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && (resp.kind == RESP_SINGLE) |=> m_tvalid && m_tlast && !busy)
		else $error("single response not marked last");

	a_absorb_is_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && (resp.kind == RESP_NONE) |=> !m_tvalid)
		else $error("absorbed symbol produced output");

endmodule

`default_nettype wire
